### hw/rtl/hq_pkg.sv
`default_nettype none

package hq_pkg;

    // Fixed sample format: unsigned Q0.16
    localparam int SAMPLE_BITS    = 16;
    localparam int BINS_DEF       = 256;
    localparam int COUNT_BITS_DEF = 22;

    // APB address width: two 32-bit registers at byte offsets 0 and 4
    localparam int PADDR_W = 3;

    localparam logic [SAMPLE_BITS-1:0] LOW_BOUND_RESET  = 16'h0000;
    localparam logic [SAMPLE_BITS-1:0] HIGH_BOUND_RESET = 16'hFFFF;

    // Register index codes
    typedef enum logic {
        REG_LOW_BOUND  = 1'b0,
        REG_HIGH_BOUND = 1'b1
    } hq_reg_t;

    // Range setting handed from the register file to the datapath
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] low;
        logic [SAMPLE_BITS-1:0] high;
    } hq_bounds_t;

endpackage

`default_nettype wire

### hw/rtl/histogram_equalizer_unit.sv
`default_nettype none

// Channel   Dir  Handshake          Word
// s_        in   s_valid/s_ready    s_func, s_sample, s_last
// m_        out  m_valid/m_ready    m_mapped_value, m_passed_through
// APB       in   psel/penable       paddr, pwdata, prdata (pready tied high)
//
// One word at a time. An in-range sample first passes through the bin
// divider. The count word marked last then builds the table, one bin at a
// time through the divider and memory. After reset and after each map
// word marked last a clearing pass writes every entry of the count memory,
// with s_ready low. A waiting result in the output register does not block
// the next input word.
module histogram_equalizer_unit #(
    parameter int BINS       = hq_pkg::BINS_DEF,
    parameter int COUNT_BITS = hq_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_func,
    input  wire logic [hq_pkg::SAMPLE_BITS-1:0]   s_sample,
    input  wire logic                             s_last,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [hq_pkg::SAMPLE_BITS-1:0]   m_mapped_value,
    output logic                                  m_passed_through,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [hq_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready
);

    localparam int SB = hq_pkg::SAMPLE_BITS;
    localparam int CB = COUNT_BITS;
    localparam int LB = $clog2(BINS);
    localparam int DW = (CB > SB) ? CB : SB;
    localparam int QW = LB + SB;
    localparam int SW = $clog2(QW + 1);
    localparam logic [LB-1:0] LAST_BIN = LB'(BINS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOCATE, S_CRD, S_CWR, S_MRD0, S_MRD1, S_MMUL,
        S_RESULT, S_BRD, S_BACC, S_BDIV, S_BWAIT, S_BWR
    } state_t;

    state_t state_reg;

    hq_pkg::hq_bounds_t bounds;

    logic          func_reg;
    logic          last_reg;
    logic [SB-1:0] sample_reg;
    logic [LB-1:0] bin_reg;
    logic [SB-1:0] frac_reg;
    logic [SB-1:0] val_reg;
    logic          pass_reg;
    logic [CB-1:0] total_reg;
    logic          table_ready_reg;
    logic [LB-1:0] clr_reg;
    logic [LB-1:0] k_reg;
    logic [CB+LB-1:0] cum_reg;
    logic [2*SB:0] p0_reg;
    logic          m_valid_reg;
    logic [SB-1:0] m_value_reg;
    logic          m_pass_reg;

    // register file
    hq_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bounds  (bounds)
    );

    // input classification against the range
    logic          below;
    logic          empty;
    logic [SB-1:0] d_w;
    logic [SB-1:0] range_w;
    logic          in_range;
    logic [SB+LB-1:0] prod_w;

    assign below    = s_sample < bounds.low;
    assign empty    = bounds.high <= bounds.low;
    assign d_w      = s_sample - bounds.low;
    assign range_w  = bounds.high - bounds.low;
    assign in_range = !below && !empty && (d_w < range_w);
    assign prod_w   = (SB+LB)'(d_w) * (SB+LB)'(BINS);

    // table entry numerator: cum * 2^SB + total/2
    logic [CB+SB-1:0] n_w;
    logic             cum_ge;
    assign n_w    = {cum_reg[CB-1:0], {SB{1'b0}}} + (CB+SB)'(total_reg >> 1);
    assign cum_ge = cum_reg >= (CB+LB)'(total_reg);

    // shared divider
    logic          div_start;
    logic [DW-1:0] div_init;
    logic [DW-1:0] div_divisor;
    logic [QW-1:0] div_low;
    logic [SW-1:0] div_steps;
    logic          div_busy;
    logic [QW-1:0] div_quot;
    logic          build_sel;

    assign build_sel   = (state_reg == S_BDIV);
    assign div_start   = (state_reg == S_IDLE && s_valid && in_range) ||
                         (build_sel && total_reg != '0 && !cum_ge);
    assign div_init    = build_sel ? DW'(n_w[CB+SB-1:SB+1]) : DW'(prod_w[SB+LB-1:LB]);
    assign div_divisor = build_sel ? DW'(total_reg) : DW'(range_w);
    assign div_low     = build_sel ? {n_w[SB:0], {(QW-SB-1){1'b0}}}
                                   : {prod_w[LB-1:0], {SB{1'b0}}};
    assign div_steps   = build_sel ? SW'(SB + 1) : SW'(QW);

    hq_div #(.DW(DW), .QW(QW), .SW(SW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .init_rem (div_init),
        .divisor  (div_divisor),
        .low_bits (div_low),
        .steps    (div_steps),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    // bin count memory
    logic          bin_we;
    logic [LB-1:0] bin_waddr;
    logic [CB-1:0] bin_wdata;
    logic [LB-1:0] bin_raddr;
    logic [CB-1:0] bin_rdata;
    logic [CB-1:0] bin_inc;

    assign bin_inc   = (&bin_rdata) ? bin_rdata : bin_rdata + CB'(1);
    assign bin_we    = (state_reg == S_CLEAR) || (state_reg == S_CWR);
    assign bin_waddr = (state_reg == S_CLEAR) ? clr_reg : bin_reg;
    assign bin_wdata = (state_reg == S_CLEAR) ? '0 : bin_inc;
    assign bin_raddr = (state_reg == S_BRD) ? k_reg : bin_reg;

    hq_ram #(.WIDTH(CB), .DEPTH(BINS), .AW(LB)) u_bin_ram (
        .aclk  (aclk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    // cumulative table memory
    logic [LB-1:0] bin1;
    logic [LB-1:0] tab_raddr;
    logic [SB-1:0] tab_rdata;

    assign bin1      = (bin_reg == LAST_BIN) ? bin_reg : bin_reg + LB'(1);
    assign tab_raddr = (state_reg == S_MRD1) ? bin1 : bin_reg;

    hq_ram #(.WIDTH(SB), .DEPTH(BINS), .AW(LB)) u_tab_ram (
        .aclk  (aclk),
        .we    (state_reg == S_BWR),
        .waddr (k_reg),
        .wdata (val_reg),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // blend arithmetic
    logic [SB:0]     omf;
    logic [2*SB+1:0] acc;
    logic [LB-1:0]   q_bin;

    assign omf   = {1'b1, {SB{1'b0}}} - {1'b0, frac_reg};
    assign acc   = (2*SB+2)'(p0_reg) + (2*SB+2)'(tab_rdata) * (2*SB+2)'(frac_reg)
                 + (2*SB+2)'(1 << (SB - 1));
    assign q_bin = div_quot[QW-1:SB];

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            total_reg       <= '0;
            table_ready_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            // the result state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + LB'(1);
                    if (clr_reg == LAST_BIN) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        func_reg   <= s_func;
                        last_reg   <= s_last;
                        sample_reg <= s_sample;
                        frac_reg   <= '0;
                        bin_reg    <= below ? '0 : LAST_BIN;
                        if (in_range) begin
                            state_reg <= S_LOCATE;
                        end else if (!s_func) begin
                            state_reg <= S_CRD;
                        end else if (!table_ready_reg || !below) begin
                            val_reg   <= s_sample;
                            pass_reg  <= 1'b1;
                            state_reg <= S_RESULT;
                        end else begin
                            state_reg <= S_MRD0;
                        end
                    end
                end
                S_LOCATE: begin
                    if (!div_busy) begin
                        bin_reg  <= q_bin;
                        frac_reg <= (q_bin == LAST_BIN) ? '0 : div_quot[SB-1:0];
                        if (!func_reg) begin
                            state_reg <= S_CRD;
                        end else if (!table_ready_reg) begin
                            val_reg   <= sample_reg;
                            pass_reg  <= 1'b1;
                            state_reg <= S_RESULT;
                        end else begin
                            state_reg <= S_MRD0;
                        end
                    end
                end
                S_CRD: state_reg <= S_CWR;
                S_CWR: begin
                    if (!(&total_reg)) begin
                        total_reg <= total_reg + CB'(1);
                    end
                    if (last_reg) begin
                        k_reg     <= '0;
                        cum_reg   <= '0;
                        state_reg <= S_BRD;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_MRD0: state_reg <= S_MRD1;
                S_MRD1: begin
                    p0_reg    <= (2*SB+1)'(tab_rdata) * (2*SB+1)'(omf);
                    state_reg <= S_MMUL;
                end
                S_MMUL: begin
                    val_reg   <= acc[2*SB-1:SB];
                    pass_reg  <= 1'b0;
                    state_reg <= S_RESULT;
                end
                S_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= val_reg;
                        m_pass_reg  <= pass_reg;
                        if (last_reg) begin
                            total_reg       <= '0;
                            table_ready_reg <= 1'b0;
                            clr_reg         <= '0;
                            state_reg       <= S_CLEAR;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_BRD: state_reg <= S_BACC;
                S_BACC: begin
                    cum_reg   <= cum_reg + (CB+LB)'(bin_rdata);
                    state_reg <= S_BDIV;
                end
                S_BDIV: begin
                    if (total_reg == '0) begin
                        val_reg   <= '0;
                        state_reg <= S_BWR;
                    end else if (cum_ge) begin
                        val_reg   <= '1;
                        state_reg <= S_BWR;
                    end else begin
                        state_reg <= S_BWAIT;
                    end
                end
                S_BWAIT: begin
                    if (!div_busy) begin
                        val_reg   <= div_quot[SB] ? '1 : div_quot[SB-1:0];
                        state_reg <= S_BWR;
                    end
                end
                S_BWR: begin
                    if (k_reg == LAST_BIN) begin
                        table_ready_reg <= 1'b1;
                        state_reg       <= S_IDLE;
                    end else begin
                        k_reg     <= k_reg + LB'(1);
                        state_reg <= S_BRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_mapped_value   = m_value_reg;
    assign m_passed_through = m_pass_reg;

    // only map words reach the result stage
    a_result_is_map: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESULT |-> func_reg)
        else $error("count word reached result stage");

    // divider runs only while a state waits on it
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == S_LOCATE || state_reg == S_BWAIT))
        else $error("divider busy outside a waiting state");

    // table is dropped only by a frame end, which starts a clearing pass
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(table_ready_reg) |-> state_reg == S_CLEAR)
        else $error("table ready dropped without clear");

    // writing the last table entry makes the table ready
    a_build_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BWR && k_reg == LAST_BIN) |=> table_ready_reg)
        else $error("table not ready after build");

endmodule

`default_nettype wire

### hw/rtl/hq_ram.sv
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port
module hq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/hq_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Remainder starts at init_rem (must be below divisor); the bits of
// low_bits are shifted in MSB first, 'steps' of them in all.
module hq_div #(
    parameter int DW = 22,
    parameter int QW = 24,
    parameter int SW = $clog2(QW + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] init_rem,
    input  wire logic [DW-1:0] divisor,
    input  wire logic [QW-1:0] low_bits,
    input  wire logic [SW-1:0] steps,
    output logic               busy,
    output logic      [QW-1:0] quot
);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [QW-1:0] bits_reg;
    logic [QW-1:0] quot_reg;
    logic [SW-1:0] cnt_reg;
    logic          busy_reg;

    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        ge;

    // one trial subtraction per cycle
    assign shifted = {rem_reg, bits_reg[QW-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            rem_reg  <= init_rem;
            div_reg  <= divisor;
            bits_reg <= low_bits;
            quot_reg <= '0;
            cnt_reg  <= steps;
            busy_reg <= (steps != '0);
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            bits_reg <= {bits_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], ge};
            cnt_reg  <= cnt_reg - SW'(1);
            if (cnt_reg == SW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

### hw/rtl/hq_cfg.sv
`default_nettype none

// APB register file: low and high bound
module hq_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output hq_pkg::hq_bounds_t               bounds
);

    logic [hq_pkg::SAMPLE_BITS-1:0] low_reg;
    logic [hq_pkg::SAMPLE_BITS-1:0] high_reg;
    hq_pkg::hq_reg_t                idx;
    logic                           wr_en;

    assign idx   = hq_pkg::hq_reg_t'(paddr[hq_pkg::PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= hq_pkg::LOW_BOUND_RESET;
            high_reg <= hq_pkg::HIGH_BOUND_RESET;
        end else if (wr_en) begin
            unique case (idx)
                hq_pkg::REG_LOW_BOUND:  low_reg  <= pwdata[hq_pkg::SAMPLE_BITS-1:0];
                hq_pkg::REG_HIGH_BOUND: high_reg <= pwdata[hq_pkg::SAMPLE_BITS-1:0];
                default:                ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            hq_pkg::REG_LOW_BOUND:  prdata = 32'(low_reg);
            hq_pkg::REG_HIGH_BOUND: prdata = 32'(high_reg);
            default:                prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign bounds.low  = low_reg;
    assign bounds.high = high_reg;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hq_pkg::*;

    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;
    localparam int   BIN_LAST   = BINS_DEF - 1;
    localparam int   SETTLE     = 8000;      // table build plus clearing pass
    localparam int   HOLD_LEN   = 3000;
    localparam longint LIMIT    = 5_000_000;

    typedef enum int {BIN_BELOW, BIN_INSIDE, BIN_BEYOND} bin_where_t;

    typedef struct {
        logic                   func;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } pixel_word_t;

    typedef struct {
        logic [SAMPLE_BITS-1:0] value;
        logic                   pass;
    } mapped_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_func = 1'b0;
    logic [SAMPLE_BITS-1:0] s_sample = '0;
    logic                   s_last = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [SAMPLE_BITS-1:0] m_mapped_value;
    logic                   m_passed_through;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    histogram_equalizer_unit dut (.*);

    // shadow state of the equalizer
    logic [SAMPLE_BITS-1:0] low_reg, high_reg;
    logic [21:0]            bin_count [BINS_DEF];
    logic [21:0]            pixel_sum;
    logic [SAMPLE_BITS-1:0] cdf_table [BINS_DEF];
    logic                   cdf_valid;

    pixel_word_t  pixel_q [$];
    mapped_word_t mapped_q [$];
    int  send_idle_pct = 0, recv_idle_pct = 0;
    int  err_count = 0, map_checked = 0, words_in = 0, tables_built = 0;
    bit  in_fire = 1'b0;
    bit  hold_req = 1'b0, hold_done = 1'b0;
    int  hold_left = 0;
    longint cycle = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report(input string what, input longint got, input longint want);
        err_count++;
        $display("mismatch @%0d: %s got %0h want %0h", cycle, what, got, want);
    endtask

    function automatic bin_where_t find_bin(input logic [15:0] s, output int bin,
                                            output logic [15:0] frac);
        logic [63:0] pos;
        bin  = 0;
        frac = '0;
        if (s < low_reg) return BIN_BELOW;
        if (high_reg <= low_reg) return BIN_BEYOND;
        pos = (64'(s - low_reg) << 24) / 64'(high_reg - low_reg);
        if ((pos >> 16) >= BINS_DEF) return BIN_BEYOND;
        bin  = int'(pos >> 16);
        frac = pos[15:0];
        return BIN_INSIDE;
    endfunction

    task automatic equalize_word(input pixel_word_t w);
        int           bin;
        logic [15:0]  frac;
        bin_where_t   where;
        logic [63:0]  cum, v;
        mapped_word_t r;
        where = find_bin(w.sample, bin, frac);
        if (w.func == FUNC_COUNT) begin
            if (where == BIN_BEYOND) bin = BIN_LAST;
            if (bin_count[bin] != '1) bin_count[bin]++;
            if (pixel_sum != '1) pixel_sum++;
            if (w.last) begin
                cum = 0;
                for (int k = 0; k < BINS_DEF; k++) begin
                    cum += bin_count[k];
                    v = (cum * 65536 + pixel_sum / 2) / pixel_sum;
                    cdf_table[k] = (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
                end
                cdf_valid = 1'b1;
                tables_built++;
            end
        end else begin
            r.pass = 1'b0;
            if (!cdf_valid || where == BIN_BEYOND) begin
                r.value = w.sample;
                r.pass  = 1'b1;
            end else if (where == BIN_BELOW || bin == BIN_LAST) begin
                r.value = cdf_table[bin];
            end else begin
                v = (64'(cdf_table[bin]) * (65536 - frac) + 64'(cdf_table[bin+1]) * frac
                     + 32768) >> 16;
                r.value = v[15:0];
            end
            mapped_q = {mapped_q, r};
            if (w.last) begin
                foreach (bin_count[k]) bin_count[k] = '0;
                pixel_sum = '0;
                cdf_valid = 1'b0;
            end
        end
    endtask

    // cycle count and timeout
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // monitor: accept input words into the predictor, check output words
    always @(posedge aclk) begin
        mapped_word_t e;
        in_fire <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            words_in++;
            equalize_word('{s_func, s_sample, s_last});
        end
        if (aresetn && m_valid && m_ready) begin
            if (mapped_q.size() == 0) begin
                report("unexpected word", m_mapped_value, 0);
            end else begin
                e = mapped_q.pop_front();
                map_checked++;
                if (m_mapped_value !== e.value) report("mapped_value", m_mapped_value, e.value);
                if (m_passed_through !== e.pass)
                    report("passed_through", m_passed_through, e.pass);
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        pixel_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (in_fire || !s_valid) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pixel_q.pop_front();
                s_func   <= w.func;
                s_sample <= w.sample;
                s_last   <= w.last;
                s_valid  <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apb_write(input hq_reg_t idx, input logic [15:0] val);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = PADDR_W'(int'(idx) * 4); pwdata = {16'h0, val};
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        pwrite = 1'b0; penable = 1'b0;
        if (idx == REG_LOW_BOUND) low_reg = val; else high_reg = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata[15:0] !== val) report("register readback", prdata[15:0], val);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 16'($urandom_range(low_reg, high_reg));
        if (r < 85) return 16'($urandom);
        case ($urandom_range(5))
            0: return low_reg;
            1: return high_reg;
            2: return low_reg - 16'd1;
            3: return high_reg - 16'd1;
            4: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic void push_word(input logic f, input logic [15:0] s, input logic l);
        pixel_word_t w;
        w = '{f, s, l};
        pixel_q = {pixel_q, w};
    endfunction

    task automatic drain();
        wait (pixel_q.size() == 0 && !s_valid && mapped_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    logic [15:0] lo_set [8] = '{16'h0000, 16'h1000, 16'h8000, 16'hC000,
                                16'h0000, 16'hFFFF, 16'h1234, 16'h0000};
    logic [15:0] hi_set [8] = '{16'hFFFF, 16'hF000, 16'h8000, 16'h4000,
                                16'h0000, 16'hFFFF, 16'h1334, 16'h0001};

    initial begin
        int n;
        low_reg = LOW_BOUND_RESET;
        high_reg = HIGH_BOUND_RESET;
        foreach (bin_count[k]) begin
            bin_count[k] = '0;
            cdf_table[k] = '0;
        end
        pixel_sum = '0;
        cdf_valid = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: map before any table, field extremes, last bin, pass-through
        push_word(FUNC_MAP, 16'h0005, 1'b0);
        push_word(FUNC_MAP, 16'hFFFF, 1'b0);
        push_word(FUNC_COUNT, 16'h0000, 1'b0);
        push_word(FUNC_COUNT, 16'hFFFF, 1'b0);
        push_word(FUNC_COUNT, 16'hFFFE, 1'b0);
        push_word(FUNC_COUNT, 16'h8000, 1'b0);
        push_word(FUNC_COUNT, 16'h7FFF, 1'b1);
        push_word(FUNC_MAP, 16'h0000, 1'b0);
        push_word(FUNC_MAP, 16'hFFFF, 1'b0);
        push_word(FUNC_MAP, 16'hFFFE, 1'b0);
        push_word(FUNC_MAP, 16'h8000, 1'b0);
        push_word(FUNC_MAP, 16'h7FFF, 1'b0);
        push_word(FUNC_MAP, 16'h5555, 1'b0);
        push_word(FUNC_COUNT, 16'hAAAA, 1'b0);
        push_word(FUNC_MAP, 16'hAAAA, 1'b1);
        push_word(FUNC_MAP, 16'h1234, 1'b1);
        drain();

        // random: per range setting, two well-formed frames plus noise
        foreach (lo_set[i]) begin
            send_idle_pct = (i < 3) ? 36 : (i < 6) ? 67 : 0;
            recv_idle_pct = (i < 3) ? 67 : (i < 6) ? 36 : 0;
            apb_write(REG_LOW_BOUND, lo_set[i]);
            apb_write(REG_HIGH_BOUND, hi_set[i]);
            if (i == 6) hold_req = 1'b1;
            for (int f = 0; f < 2; f++) begin
                n = $urandom_range(20, 60);
                for (int k = 0; k < n; k++) push_word(FUNC_COUNT, pick_sample(), k == n - 1);
                n = $urandom_range(20, 60);
                for (int k = 0; k < n; k++) push_word(FUNC_MAP, pick_sample(), k == n - 1);
            end
            for (int k = 0; k < 20; k++)
                push_word(1'($urandom), pick_sample(), $urandom_range(9) == 0);
            drain();
        end

        $display("%0d words sent over 8 range settings, %0d tables built, %0d results checked",
                 words_in, tables_built, map_checked);
        $display("covered empty, inverted and narrow ranges, pass-through and a long stall");
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", err_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/hq_pkg.sv
hw/rtl/hq_ram.sv
hw/rtl/hq_div.sv
hw/rtl/hq_cfg.sv
hw/rtl/histogram_equalizer_unit.sv
verif/testbench.sv
